[src/equal_length_pattern_replace_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef EQUAL_LENGTH_PATTERN_REPLACE_DEFINES_SVH
`define EQUAL_LENGTH_PATTERN_REPLACE_DEFINES_SVH

// same-cycle implication
`define ELPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ELPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/elpr_pkg.sv]
// ----------------------------------------------------------------------------
// elpr_pkg
// Word types, codes and defaults of the pattern replace block.
// ----------------------------------------------------------------------------
package elpr_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	typedef enum logic [1:0] {
		KIND_PATTERN = 2'd0,
		KIND_REPLACE = 2'd1,
		KIND_DATA    = 2'd2
	} kind_t;

	localparam logic REG_PATTERN_LENGTH = 1'b0;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] table_index;
		logic [7:0] byte_value;
		logic       buffer_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic [31:0] replaced_count;
	} out_word_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic replace;
	} cell_ctl_t;

endpackage

[src/equal_length_pattern_replace.sv]
// ----------------------------------------------------------------------------
// equal_length_pattern_replace
// Fixed-length byte pattern search and replace over a streamed buffer.
// ----------------------------------------------------------------------------
// Data bytes pass through a chain of MAX_PATTERN+2 byte cells. For each
// accepted data byte the oldest pattern_length cells are compared in
// parallel against the pattern, overwritten with the replacement on a match,
// and once the window holds pattern_length+1 bytes every new byte pushes one
// result out, so the steady rate is one byte per cycle. After a byte marked
// last the chain drains one held byte per cycle while the result queue has
// room, and no word is taken during the drain. Results leave through a
// two-word queue; outside the drain the input stalls only when it is full.
// pattern_length is read at byte address 0 of the APB port.
`include "equal_length_pattern_replace_defines.svh"
module equal_length_pattern_replace #(
	parameter int MAX_PATTERN = elpr_pkg::MAX_PATTERN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  elpr_pkg::in_word_t  src_word,
	output logic                res_valid,
	input  logic                res_ready,
	output elpr_pkg::out_word_t res_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import elpr_pkg::*;

	localparam int DEPTH  = MAX_PATTERN + 2;
	localparam int FILL_W = $clog2(DEPTH);
	localparam int CW     = FILL_W + 1;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

	logic [5:0]                  cfg_len_q;
	logic [LEN_W-1:0]            len;
	logic [FILL_W-1:0]           fill_q;
	logic                        drain_q;
	logic [31:0]                 total_q;
	logic [31:0]                 total_inc;

	logic [MAX_PATTERN-1:0][7:0] pat;
	logic [MAX_PATTERN-1:0][7:0] rep;
	cell_ctl_t                   ctl      [DEPTH];
	logic [7:0]                  cell_cur [DEPTH];
	logic [DEPTH-1:0]            cell_eq;
	logic [DEPTH-1:0]            mask;

	logic      accept;
	logic      step_data;
	logic      drain_go;
	logic      cmp_en;
	logic      emit_d;
	logic      match;
	logic      shift;
	logic      fifo_full;
	logic      out_last;
	out_word_t push_word;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q <= 6'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PATTERN_LENGTH) begin
			cfg_len_q <= pwdata[5:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PATTERN_LENGTH) begin
			prdata = 32'(cfg_len_q);
		end
	end

	always_comb begin
		if (cfg_len_q == 6'd0) begin
			len = LEN_W'(1);
		end else if (cfg_len_q > 6'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(cfg_len_q);
		end
	end

	// handshake and step control
	assign src_ready = !drain_q && !fifo_full;
	assign accept    = src_valid && src_ready;
	assign step_data = accept && src_word.kind == KIND_DATA;
	assign drain_go  = drain_q && !fifo_full;

	assign cmp_en = (CW'(fill_q) == CW'(len) + CW'(1));
	assign emit_d = src_word.buffer_last || (CW'(fill_q) >= CW'(len) + CW'(1));

	for (genvar i = 0; i < DEPTH; i++) begin : g_mask
		if (i < MAX_PATTERN) begin : g_act
			assign mask[i] = (LEN_W'(i) < len);
		end else begin : g_tail
			assign mask[i] = 1'b0;
		end
	end

	assign match = cmp_en && (&(cell_eq | ~mask));
	assign shift = (step_data && emit_d) || drain_go;

	assign total_inc = (match && total_q != '1) ? total_q + 32'd1 : total_q;

	// tables
	elpr_store #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_store (
		.clk      (clk),
		.pat_wr   (accept && src_word.kind == KIND_PATTERN),
		.rep_wr   (accept && src_word.kind == KIND_REPLACE),
		.wr_index (src_word.table_index),
		.wr_value (src_word.byte_value),
		.pat      (pat),
		.rep      (rep)
	);

	// cell chain, cell 0 holds the oldest byte
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] pat_b;
		logic [7:0] rep_b;
		logic [7:0] nb_b;

		if (i < MAX_PATTERN) begin : g_tab
			assign pat_b = pat[i];
			assign rep_b = rep[i];
		end else begin : g_notab
			assign pat_b = 8'h00;
			assign rep_b = 8'h00;
		end

		if (i < DEPTH - 1) begin : g_nb
			assign nb_b = cell_cur[i+1];
		end else begin : g_end
			assign nb_b = 8'h00;
		end

		assign ctl[i].shift   = shift;
		assign ctl[i].load    = step_data && fill_q == FILL_W'(i);
		assign ctl[i].replace = step_data && match && mask[i];

		elpr_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.src_byte (src_word.byte_value),
			.pat_byte (pat_b),
			.rep_byte (rep_b),
			.nb_byte  (nb_b),
			.cur_byte (cell_cur[i]),
			.eq       (cell_eq[i])
		);
	end

	// result word
	assign out_last = step_data ? (src_word.buffer_last && fill_q == '0)
	                            : (fill_q == FILL_W'(1));

	always_comb begin
		push_word.out_byte       = cell_cur[0];
		push_word.out_last       = out_last;
		push_word.replaced_count = out_last ? total_inc : 32'd0;
	end

	elpr_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (shift),
		.push_word (push_word),
		.full      (fifo_full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	// fill, drain and match count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			drain_q <= 1'b0;
			total_q <= '0;
		end else if (step_data) begin
			fill_q <= emit_d ? fill_q : fill_q + FILL_W'(1);
			if (src_word.buffer_last) begin
				drain_q <= (fill_q != '0);
				total_q <= (fill_q != '0) ? total_inc : 32'd0;
			end else begin
				total_q <= total_inc;
			end
		end else if (drain_go) begin
			fill_q <= fill_q - FILL_W'(1);
			if (fill_q == FILL_W'(1)) begin
				drain_q <= 1'b0;
				total_q <= '0;
			end
		end
	end

	// assertions
	`ELPR_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(DEPTH - 1), "window fill overrun")
	`ELPR_ASSERT_IMP(a_drain_fill, drain_q, fill_q != '0, "drain with empty window")
	`ELPR_ASSERT_NXT(a_last_flush, step_data && src_word.buffer_last, drain_q || fill_q == '0, "last byte did not flush")

endmodule

[src/elpr_store.sv]
// ----------------------------------------------------------------------------
// elpr_store
// Pattern and replacement byte registers, one pair per pattern position.
// ----------------------------------------------------------------------------
module elpr_store #(
	parameter int MAX_PATTERN = elpr_pkg::MAX_PATTERN_DEF
) (
	input  logic                        clk,
	input  logic                        pat_wr,
	input  logic                        rep_wr,
	input  logic [4:0]                  wr_index,
	input  logic [7:0]                  wr_value,
	output logic [MAX_PATTERN-1:0][7:0] pat,
	output logic [MAX_PATTERN-1:0][7:0] rep
);
	import elpr_pkg::*;

	logic [MAX_PATTERN-1:0][7:0] pat_q;
	logic [MAX_PATTERN-1:0][7:0] rep_q;

	for (genvar e = 0; e < MAX_PATTERN; e++) begin : g_entry
		always_ff @(posedge clk) begin
			if (pat_wr && int'(wr_index) == e) begin
				pat_q[e] <= wr_value;
			end
			if (rep_wr && int'(wr_index) == e) begin
				rep_q[e] <= wr_value;
			end
		end
	end

	assign pat = pat_q;
	assign rep = rep_q;

endmodule

[src/elpr_cell.sv]
// ----------------------------------------------------------------------------
// elpr_cell
// One window position: holds a byte, compares it, replaces, loads or shifts.
// ----------------------------------------------------------------------------
module elpr_cell (
	input  logic                clk,
	input  elpr_pkg::cell_ctl_t ctl,
	input  logic [7:0]          src_byte,
	input  logic [7:0]          pat_byte,
	input  logic [7:0]          rep_byte,
	input  logic [7:0]          nb_byte,
	output logic [7:0]          cur_byte,
	output logic                eq
);
	import elpr_pkg::*;

	logic [7:0] data_q;

	assign eq = (data_q == pat_byte);

	always_comb begin
		if (ctl.replace) begin
			cur_byte = rep_byte;
		end else if (ctl.load) begin
			cur_byte = src_byte;
		end else begin
			cur_byte = data_q;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= ctl.shift ? nb_byte : cur_byte;
	end

endmodule

[src/elpr_out_fifo.sv]
// ----------------------------------------------------------------------------
// elpr_out_fifo
// Two-word result queue between the cell chain and the output channel.
// ----------------------------------------------------------------------------
module elpr_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  elpr_pkg::out_word_t push_word,
	output logic                full,
	output logic                res_valid,
	input  logic                res_ready,
	output elpr_pkg::out_word_t res_word
);
	import elpr_pkg::*;

	out_word_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign res_valid = (cnt_q != 2'd0);
	assign res_word  = mem_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[dv/elpr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elpr_checker
// Watches the source, result and APB ports of the pattern replace block,
// keeps its own copy of the delay window, the pattern and replacement tables
// and pattern_length, predicts every result word and compares them in order.
// ----------------------------------------------------------------------------
module elpr_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_ready,
	input  elpr_pkg::in_word_t  src_word,
	input  logic                res_valid,
	input  logic                res_ready,
	input  elpr_pkg::out_word_t res_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic [31:0]         prdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  words_pending,
	output int                  words_checked,
	output int                  matches_seen
);
	import elpr_pkg::*;

	localparam int WIN_DEPTH = MAX_PATTERN_DEF + 2;
	localparam logic [2:0] LEN_ADDR = 3'(4 * REG_PATTERN_LENGTH);

	logic [7:0]  window [WIN_DEPTH];
	int          window_fill;
	logic [7:0]  pattern_tab [MAX_PATTERN_DEF];
	logic [7:0]  replace_tab [MAX_PATTERN_DEF];
	logic [31:0] buffer_matches;
	logic [5:0]  length_reg;
	out_word_t   expected_words [$];
	out_word_t   head;

	function automatic int active_length();
		int n;
		n = length_reg;
		if (n < 1)
			n = 1;
		if (n > MAX_PATTERN_DEF)
			n = MAX_PATTERN_DEF;
		return n;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// oldest held byte leaves the window as one result word
	task automatic release_oldest(input logic last_flag, input logic [31:0] count);
		out_word_t w;
		w.out_byte       = window[0];
		w.out_last       = last_flag;
		w.replaced_count = count;
		expected_words.push_back(w);
		for (int i = 0; i < WIN_DEPTH - 1; i++)
			window[i] = window[i + 1];
		window[WIN_DEPTH - 1] = 8'h00;
		window_fill--;
	endtask

	task automatic predict_word(input in_word_t w);
		int   len;
		int   start;
		logic hit;
		len = active_length();
		case (w.kind)
		KIND_PATTERN: pattern_tab[w.table_index] = w.byte_value;
		KIND_REPLACE: replace_tab[w.table_index] = w.byte_value;
		KIND_DATA: begin
			if (window_fill >= WIN_DEPTH)
				release_oldest(1'b0, 32'd0);
			window[window_fill] = w.byte_value;
			window_fill++;
			// window ending two bytes behind the newest one
			if (window_fill >= len + 2) begin
				start = window_fill - 2 - len;
				hit = 1'b1;
				for (int i = 0; i < len; i++)
					if (window[start + i] !== pattern_tab[i])
						hit = 1'b0;
				if (hit) begin
					for (int i = 0; i < len; i++)
						window[start + i] = replace_tab[i];
					if (buffer_matches != '1)
						buffer_matches++;
					matches_seen++;
				end
			end
			if (w.buffer_last) begin
				while (window_fill > 0)
					release_oldest(window_fill == 1, (window_fill == 1) ? buffer_matches : 32'd0);
				buffer_matches = '0;
			end else begin
				while (window_fill > len + 1)
					release_oldest(1'b0, 32'd0);
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (window[i])
				window[i] = 8'h00;
			foreach (pattern_tab[i]) begin
				pattern_tab[i] = 8'h00;
				replace_tab[i] = 8'h00;
			end
			window_fill = 0;
			buffer_matches = '0;
			length_reg = 6'd1;
			expected_words.delete();
			fail_count = 0;
			words_pending = 0;
			words_checked = 0;
			matches_seen = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h",
						$time, res_word);
					fail_count++;
				end else begin
					head = expected_words.pop_front();
					compare_field("out_byte", 32'(head.out_byte), 32'(res_word.out_byte));
					compare_field("out_last", 32'(head.out_last), 32'(res_word.out_last));
					compare_field("replaced_count", head.replaced_count, res_word.replaced_count);
					words_checked++;
				end
			end
			if (psel && penable && pready && paddr == LEN_ADDR) begin
				if (pwrite)
					length_reg = pwdata[5:0];
				else
					compare_field("pattern_length read", {26'd0, length_reg}, prdata);
			end
			if (src_valid && src_ready)
				predict_word(src_word);
			words_pending = expected_words.size();
		end
	end

endmodule

[dv/tb_equal_length_pattern_replace.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_equal_length_pattern_replace
// Drives pattern and replacement loads and data buffers into the block in
// bursts, stalls the result side on shifting patterns and once for a long
// hold, steps pattern_length through its range between buffers, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_equal_length_pattern_replace;
	import elpr_pkg::*;

	localparam int LIMIT_CYCLES      = 500000;
	localparam int SETTLE_CYCLES     = 48;
	localparam int LONG_HOLD_CYCLES  = 300;
	localparam int RANDOM_DATA_WORDS = 150;
	localparam logic [2:0] LEN_ADDR  = 3'(4 * REG_PATTERN_LENGTH);
	localparam logic [1:0] KIND_IGNORED = 2'b11;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_PERIODIC
	} ready_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	in_word_t    src_word  = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	out_word_t   res_word;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int words_pending;
	int words_checked;
	int matches_seen;

	int          burst_left    = 0;
	int          hold_requests = 0;
	int          holds_done    = 0;
	int          hold_left     = 0;
	int          mode_left     = 0;
	ready_mode_t ready_mode    = RDY_ALWAYS;
	int          data_words    = 0;
	int          buffers_sent  = 0;
	int          settings_made = 0;
	logic [7:0]  pattern_copy [MAX_PATTERN_DEF];
	logic [7:0]  alphabet [3];

	equal_length_pattern_replace dut (
		.clk, .arst_n,
		.src_valid, .src_ready, .src_word,
		.res_valid, .res_ready, .res_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	elpr_checker u_checker (
		.clk, .arst_n,
		.src_valid, .src_ready, .src_word,
		.res_valid, .res_ready, .res_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.fail_count, .words_pending, .words_checked, .matches_seen
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// result side: one long hold on request, else a shifting stall pattern
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= LONG_HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(8, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
			RDY_ALWAYS: res_ready <= 1'b1;
			RDY_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
			RDY_SPARSE: res_ready <= ($urandom_range(0, 4) == 0);
			default:    res_ready <= ((mode_left % 8) < 5);
			endcase
		end
	end

	function automatic in_word_t make_word(input logic [1:0] kind, input logic [4:0] idx,
		input logic [7:0] value, input logic last);
		in_word_t w;
		w.kind        = kind;
		w.table_index = idx;
		w.byte_value  = value;
		w.buffer_last = last;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		src_word <= w;
		src_valid <= 1'b1;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic settle();
		src_valid <= 1'b0;
		@(posedge clk);
		wait (words_pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write pattern_length, then read it straight back
	task automatic set_length(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_made++;
	endtask

	task automatic load_tables(input int len);
		logic [7:0] rep;
		for (int i = 0; i < len; i++) begin
			pattern_copy[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom)
				: alphabet[$urandom_range(0, 2)];
			rep = ($urandom_range(0, 1) == 1) ? 8'($urandom) : alphabet[$urandom_range(0, 2)];
			send_word(make_word(KIND_PATTERN, 5'(i), pattern_copy[i], 1'($urandom)));
			send_word(make_word(KIND_REPLACE, 5'(i), rep, 1'($urandom)));
		end
	endtask

	// data mixes whole and broken copies of the pattern with random bytes,
	// plus the odd ignored word or table reload in the middle
	task automatic send_buffer(input int n_bytes, input int len);
		int         copy_pos;
		int         stop_at;
		int         idx;
		logic [7:0] b;
		copy_pos = -1;
		stop_at = 0;
		for (int i = 0; i < n_bytes; i++) begin
			if (copy_pos < 0 && $urandom_range(0, 3) == 0) begin
				copy_pos = 0;
				stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
			end
			if (copy_pos >= 0) begin
				b = pattern_copy[copy_pos];
				copy_pos++;
				if (copy_pos >= stop_at)
					copy_pos = -1;
			end else if ($urandom_range(0, 4) != 0) begin
				b = alphabet[$urandom_range(0, 2)];
			end else begin
				b = 8'($urandom);
			end
			case ($urandom_range(0, 39))
			0: send_word(make_word(KIND_IGNORED, 5'($urandom), 8'($urandom), 1'($urandom)));
			1: begin
				idx = $urandom_range(0, MAX_PATTERN_DEF - 1);
				pattern_copy[idx] = alphabet[$urandom_range(0, 2)];
				send_word(make_word(KIND_PATTERN, 5'(idx), pattern_copy[idx], 1'($urandom)));
			end
			2: send_word(make_word(KIND_REPLACE, 5'($urandom), alphabet[$urandom_range(0, 2)],
				1'($urandom)));
			default: ;
			endcase
			send_word(make_word(KIND_DATA, 5'($urandom), b, i == n_bytes - 1));
			data_words++;
		end
		buffers_sent++;
	endtask

	initial begin
		int setting;
		int len;
		int n_bytes;
		int phase;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of one: extremes, ignored kind, short and overlapping buffers
		send_word(make_word(KIND_PATTERN, 5'd0, 8'h00, 1'b1));
		send_word(make_word(KIND_REPLACE, 5'd0, 8'hFF, 1'b0));
		send_word(make_word(KIND_PATTERN, 5'd31, 8'hFF, 1'b0));
		send_word(make_word(KIND_REPLACE, 5'd31, 8'h00, 1'b1));
		send_word(make_word(KIND_IGNORED, 5'd31, 8'hFF, 1'b1));
		send_word(make_word(KIND_DATA, 5'd31, 8'h00, 1'b1));
		for (int i = 0; i < 5; i++)
			send_word(make_word(KIND_DATA, 5'd0, 8'h00, i == 4));
		settle();

		// replacement that creates the next match
		set_length(32'd2);
		send_word(make_word(KIND_PATTERN, 5'd0, 8'h41, 1'b0));
		send_word(make_word(KIND_PATTERN, 5'd1, 8'h41, 1'b0));
		send_word(make_word(KIND_REPLACE, 5'd0, 8'h42, 1'b0));
		send_word(make_word(KIND_REPLACE, 5'd1, 8'h41, 1'b0));
		for (int i = 0; i < 6; i++)
			send_word(make_word(KIND_DATA, 5'd0, 8'h41, i == 5));
		for (int i = 0; i < 3; i++)
			send_word(make_word(KIND_DATA, 5'd0, 8'h41, i == 2));

		phase = 0;
		while (phase < 3 || data_words < RANDOM_DATA_WORDS) begin
			settle();
			if (phase == 0)
				setting = MAX_PATTERN_DEF;
			else if (phase == 1)
				setting = 1;
			else begin
				case ($urandom_range(0, 9))
				0: setting = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(33, 63);
				1: setting = MAX_PATTERN_DEF;
				default: setting = $urandom_range(1, 6);
				endcase
			end
			set_length({($urandom_range(0, 1) == 1) ? 26'($urandom) : 26'd0, 6'(setting)});
			len = (setting < 1) ? 1 : ((setting > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : setting);
			foreach (alphabet[k])
				alphabet[k] = 8'($urandom);
			load_tables(len);
			if (phase == 2) begin
				hold_requests++;
				send_buffer(48, len);
			end
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 5))
				0: n_bytes = $urandom_range(1, len + 1);
				1: n_bytes = len + 2;
				default: n_bytes = $urandom_range(len + 2, 2 * len + 12);
				endcase
				send_buffer(n_bytes, len);
			end
			phase++;
		end
		settle();

		$display("Covered %0d random data words in %0d buffers over %0d length settings,",
			data_words, buffers_sent, settings_made);
		$display("with one long result hold; %0d result words checked, %0d replacements.",
			words_checked, matches_seen);
		if (words_pending != 0)
			$display("%0t: %0d expected result words never arrived", $time, words_pending);
		if (fail_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[equal_length_pattern_replace.f]
+incdir+src
src/elpr_pkg.sv
src/elpr_store.sv
src/elpr_cell.sv
src/elpr_out_fifo.sv
src/equal_length_pattern_replace.sv
dv/elpr_checker.sv
dv/tb_equal_length_pattern_replace.sv
